/* hw/rtl/tflb_pkg.sv */
// Shared constants and types for the transfer-function table builder.
`default_nettype none
package tflb_pkg;
    localparam int MaxNodesDef   = 8;
    localparam int MaxSamplesDef = 32;
    localparam int ChanW         = 16;
    localparam int CountW        = 6;
    localparam logic [CountW-1:0] SampleCountRst = 6'd32;

    // Node handed from the front to the back.
    typedef struct packed {
        logic [ChanW-1:0] position;
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
        logic [ChanW-1:0] alpha;
        logic             last;
    } node_t;
endpackage
`default_nettype wire

/* hw/rtl/tflb_divider.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module tflb_divider
    import tflb_pkg::*;
#(
    parameter int W = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         go,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient
);
    localparam int CntW = $clog2(W + 1);
    logic [W-1:0]    quo_reg, quo_next;
    logic [W:0]      rem_reg, rem_next;
    logic [W-1:0]    dsr_reg, dsr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            run_reg, run_next;
    logic [W:0]      shifted;

    // Shift in one bit and subtract where it fits.
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        shifted  = {rem_reg[W-1:0], quo_reg[W-1]};
        if (go)
        begin
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = CntW'(W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = shifted - {1'b0, dsr_reg};
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
                run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = run_reg && (cnt_reg == CntW'(1));
    assign quotient = done ? quo_next : quo_reg;
endmodule
`default_nettype wire

/* hw/rtl/tflb_front.sv */
// Front: accepts node items into a two-entry queue.
`default_nettype none
module tflb_front
    import tflb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire node_t push_node,
    output logic       full,
    output logic       empty,
    input  wire logic  pop,
    output node_t      head
);
    node_t      q_reg [2];
    logic       rd_reg, wr_reg;
    logic [1:0] cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign head  = q_reg[rd_reg];

    // Advance pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= push_node;
    end
endmodule
`default_nettype wire

/* hw/rtl/tflb_back.sv */
// Back: stores, sorts and emits the texel run.
`default_nettype none
module tflb_back
    import tflb_pkg::*;
#(
    parameter int MAX_NODES   = MaxNodesDef,
    parameter int MAX_SAMPLES = MaxSamplesDef
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              avail,
    input  wire node_t             head,
    output logic                   pop,
    input  wire logic [CountW-1:0] sample_count,
    output logic                   strobe,
    output logic [ChanW-1:0]       texel_red,
    output logic [ChanW-1:0]       texel_green,
    output logic [ChanW-1:0]       texel_blue,
    output logic [ChanW-1:0]       texel_alpha,
    output logic                   run_end
);
    localparam int IdxW = $clog2(MAX_NODES);
    localparam int HW   = $clog2(MAX_NODES + 1);
    localparam int SW   = $clog2(MAX_SAMPLES + 1);
    localparam int DW   = 64;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_SORT  = 4'd1;
    localparam logic [3:0] S_ZERO  = 4'd2;
    localparam logic [3:0] S_XDIV  = 4'd3;
    localparam logic [3:0] S_CMP   = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_TDIV  = 4'd6;
    localparam logic [3:0] S_MUL   = 4'd7;
    localparam logic [3:0] S_PROD  = 4'd8;
    localparam logic [3:0] S_SUM   = 4'd9;
    localparam logic [3:0] S_CGO   = 4'd10;
    localparam logic [3:0] S_CDIV  = 4'd11;
    localparam logic [3:0] S_EMIT  = 4'd12;

    logic [ChanW-1:0]   pos_mem [MAX_NODES];
    logic [4*ChanW-1:0] col_mem [MAX_NODES];

    logic [3:0]         st_reg, st_next;
    logic [HW-1:0]      held_reg;
    logic [IdxW-1:0]    si_reg;
    logic               swapped_reg;
    logic [HW-1:0]      idx_reg;
    logic [SW-1:0]      smp_reg, ns_reg;
    logic [16:0]        x_reg;
    logic [ChanW-1:0]   p0_reg, p1_reg;
    logic [4*ChanW-1:0] c0_reg, c1_reg;
    logic [16:0]        t_reg;
    logic [1:0]         ch_reg;
    logic [ChanW-1:0]   res_reg [2];
    logic [33:0]        wa0_reg, wa1_reg;
    logic [33:0]        den_reg;
    logic [49:0]        n0_reg [3];
    logic [49:0]        n1_reg [3];
    logic [50:0]        num_reg [3];
    logic               pass_reg;

    logic             idle;
    logic             go;
    logic [DW-1:0]    dvd, dvs, quo;
    logic             dv_done;
    logic [SW-1:0]    s_clamp;
    logic             swap;
    logic             last_cmp;
    logic             last_smp;
    logic [IdxW-1:0]  si1;
    logic [ChanW-1:0] span;
    logic [16:0]      dx;
    logic [ChanW-1:0] q_sat;

    tflb_divider #(.W(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .go(go), .dividend(dvd), .divisor(dvs),
        .done(dv_done), .quotient(quo)
    );

    // Clamp the sample count into 1..MAX_SAMPLES.
    always_comb
    begin
        if (sample_count == '0)
            s_clamp = SW'(1);
        else if (32'(sample_count) > MAX_SAMPLES)
            s_clamp = SW'(MAX_SAMPLES);
        else
            s_clamp = SW'(sample_count);
    end

    assign si1      = si_reg + 1'b1;
    assign swap     = pos_mem[si_reg] > pos_mem[si1];
    assign last_cmp = (HW'(si_reg) + HW'(2)) >= held_reg;
    assign last_smp = (smp_reg + 1'b1) == ns_reg;
    assign idle     = (st_reg == S_LOAD);
    assign pop      = idle && avail;
    assign span     = (p1_reg > p0_reg) ? p1_reg - p0_reg : '0;
    assign dx       = (x_reg > 17'(p0_reg)) ? x_reg - 17'(p0_reg) : '0;
    assign q_sat    = (quo > 64'd65535) ? 16'hFFFF : quo[ChanW-1:0];

    // Sequence load, sort passes and the per-sample work.
    always_comb
    begin
        st_next = st_reg;
        go      = 1'b0;
        dvd     = '0;
        dvs     = 64'd1;
        unique case (st_reg)
            S_LOAD:
                if (pop && head.last)
                    st_next = S_SORT;
            S_SORT:
                if (held_reg <= HW'(1) || (last_cmp && !swapped_reg && !swap))
                    st_next = S_ZERO;
            S_ZERO:
            begin
                // First sample sits at x = 0.
                st_next = S_XDIV;
                go      = 1'b1;
                dvs     = 64'(s_clamp);
            end
            S_XDIV:
                if (dv_done)
                    st_next = S_CMP;
            S_CMP:
                st_next = S_RD;
            S_RD:
                if (pass_reg || (idx_reg != '0 && idx_reg >= held_reg))
                    st_next = S_EMIT;
                else if (span == '0)
                    st_next = S_MUL;
                else
                begin
                    st_next = S_TDIV;
                    go      = 1'b1;
                    dvd     = 64'(dx) << 16;
                    dvs     = 64'(span);
                end
            S_TDIV:
                if (dv_done)
                    st_next = S_MUL;
            S_MUL:
                st_next = S_PROD;
            S_PROD:
                st_next = S_SUM;
            S_SUM:
                st_next = S_CGO;
            S_CGO:
                if (t_reg == '0 || den_reg == '0)
                    st_next = S_EMIT;
                else
                begin
                    st_next = S_CDIV;
                    go      = 1'b1;
                    dvd     = 64'(num_reg[ch_reg]);
                    dvs     = 64'(den_reg);
                end
            S_CDIV:
                if (dv_done)
                    st_next = (ch_reg == 2'd2) ? S_EMIT : S_CGO;
            S_EMIT:
                if (pass_reg)
                    st_next = S_CMP;
                else if (last_smp)
                    st_next = S_LOAD;
                else
                begin
                    st_next = S_XDIV;
                    go      = 1'b1;
                    dvd     = 64'(smp_reg + 1'b1) << 16;
                    dvs     = 64'(ns_reg);
                end
            default:
                st_next = S_LOAD;
        endcase
    end

    // Advance state, count held nodes and mark texels.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_LOAD;
            held_reg <= '0;
            strobe   <= 1'b0;
            run_end  <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            strobe  <= (st_reg == S_ZERO) || (st_reg == S_EMIT);
            run_end <= (st_reg == S_EMIT) && !pass_reg && last_smp;
            if (st_reg == S_EMIT && !pass_reg && last_smp)
                held_reg <= '0;
            else if (pop && held_reg < HW'(MAX_NODES))
                held_reg <= held_reg + 1'b1;
        end
    end

    // Datapath registers and the node tables.
    always_ff @(posedge clk)
    begin
        case (st_reg)
            S_LOAD:
            begin
                si_reg      <= '0;
                swapped_reg <= 1'b0;
                if (pop && held_reg < HW'(MAX_NODES))
                begin
                    pos_mem[held_reg[IdxW-1:0]] <= head.position;
                    col_mem[held_reg[IdxW-1:0]] <= {head.alpha, head.blue, head.green,
                                                    head.red};
                end
            end
            S_SORT:
                if (held_reg > HW'(1))
                begin
                    if (swap)
                    begin
                        pos_mem[si_reg] <= pos_mem[si1];
                        pos_mem[si1]    <= pos_mem[si_reg];
                        col_mem[si_reg] <= col_mem[si1];
                        col_mem[si1]    <= col_mem[si_reg];
                    end
                    // Restart the pass at its end, remembering any swap within it.
                    if (last_cmp)
                    begin
                        si_reg      <= '0;
                        swapped_reg <= 1'b0;
                    end
                    else
                    begin
                        si_reg <= si1;
                        if (swap)
                            swapped_reg <= 1'b1;
                    end
                end
            S_ZERO:
            begin
                texel_red   <= '0;
                texel_green <= '0;
                texel_blue  <= '0;
                texel_alpha <= '0;
                smp_reg <= '0;
                ns_reg  <= s_clamp;
                idx_reg <= (pos_mem[0] == '0) ? HW'(1) : HW'(0);
            end
            S_XDIV:
                if (dv_done)
                    x_reg <= quo[16:0];
            S_CMP:
            begin
                pass_reg <= (idx_reg < held_reg)
                    && (x_reg > 17'(pos_mem[idx_reg[IdxW-1:0]]));
                if (idx_reg < held_reg)
                begin
                    p1_reg <= pos_mem[idx_reg[IdxW-1:0]];
                    c1_reg <= col_mem[idx_reg[IdxW-1:0]];
                end
                if (idx_reg == '0)
                begin
                    p0_reg <= '0;
                    c0_reg <= '0;
                end
                else
                begin
                    p0_reg <= pos_mem[IdxW'(idx_reg - 1'b1)];
                    c0_reg <= col_mem[IdxW'(idx_reg - 1'b1)];
                end
            end
            S_RD:
            begin
                t_reg <= '0;
                if (pass_reg)
                begin
                    {texel_alpha, texel_blue, texel_green, texel_red} <= c1_reg;
                    idx_reg <= idx_reg + 1'b1;
                end
                else if (idx_reg != '0 && idx_reg >= held_reg)
                    {texel_alpha, texel_blue, texel_green, texel_red} <= c0_reg;
            end
            S_TDIV:
                if (dv_done)
                    t_reg <= (quo > 64'd65536) ? 17'd65536 : quo[16:0];
            S_MUL:
            begin
                wa0_reg <= 34'(c0_reg[63:48]) * 34'(17'd65536 - t_reg);
                wa1_reg <= 34'(c1_reg[63:48]) * 34'(t_reg);
                ch_reg  <= 2'd0;
            end
            S_PROD:
                for (int j = 0; j < 3; j++)
                begin
                    n0_reg[j] <= 50'(c0_reg[ChanW*j +: ChanW]) * 50'(wa0_reg);
                    n1_reg[j] <= 50'(c1_reg[ChanW*j +: ChanW]) * 50'(wa1_reg);
                end
            S_SUM:
            begin
                den_reg <= wa0_reg + wa1_reg;
                for (int j = 0; j < 3; j++)
                    num_reg[j] <= 51'(n0_reg[j]) + 51'(n1_reg[j]);
            end
            S_CGO:
            begin
                texel_alpha <= den_reg[31:16];
                if (t_reg == '0)
                    {texel_blue, texel_green, texel_red} <= c0_reg[47:0];
                else if (den_reg == '0)
                    {texel_blue, texel_green, texel_red} <= '0;
            end
            S_CDIV:
                if (dv_done)
                begin
                    ch_reg <= ch_reg + 2'd1;
                    if (ch_reg == 2'd2)
                        {texel_blue, texel_green, texel_red} <= {q_sat, res_reg[1],
                                                                 res_reg[0]};
                    else
                        res_reg[ch_reg[0]] <= q_sat;
                end
            S_EMIT:
                if (!pass_reg)
                    smp_reg <= smp_reg + 1'b1;
            default:
                ;
        endcase
    end
endmodule
`default_nettype wire

/* hw/rtl/transfer_function_lut_builder.sv */
// Top level of the transfer-function table builder.
//
//  channel   | signals                                  | item moves when
//  node in   | start, busy, node_*, final_node          | start & !busy
//  config    | cfg_valid, cfg_ready, cfg_data           | cfg_valid & cfg_ready
//  texel out | strobe, texel_*, run_end                 | strobe, no stall
//
// A node enters the two-entry queue; the back pops one a cycle while loading and
// the queue holds a node. The final node starts a bubble sort, then the zero texel.
// On the shared divider a blended sample needs the x, t and three colour quotients,
// fewer when a division is skipped; a passed node needs none, a sample past the
// last node only its x quotient.
// Reset clears control only; node tables are written before they are read.
// The receiver cannot stall; busy holds off nodes while the queue is full.
`default_nettype none
module transfer_function_lut_builder
    import tflb_pkg::*;
#(
    parameter int MAX_NODES   = MaxNodesDef,
    parameter int MAX_SAMPLES = MaxSamplesDef
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [ChanW-1:0]  node_position,
    input  wire logic [ChanW-1:0]  node_red,
    input  wire logic [ChanW-1:0]  node_green,
    input  wire logic [ChanW-1:0]  node_blue,
    input  wire logic [ChanW-1:0]  node_alpha,
    input  wire logic              final_node,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CountW-1:0] cfg_data,
    output logic                   strobe,
    output logic [ChanW-1:0]       texel_red,
    output logic [ChanW-1:0]       texel_green,
    output logic [ChanW-1:0]       texel_blue,
    output logic [ChanW-1:0]       texel_alpha,
    output logic                   run_end
);
    logic [CountW-1:0] count_reg;
    node_t in_node, head;
    logic  full, empty, pop;

    assign in_node = '{position: node_position, red: node_red, green: node_green,
                       blue: node_blue, alpha: node_alpha, last: final_node};
    assign busy      = full;
    assign cfg_ready = 1'b1;

    // Hold the sample count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= SampleCountRst;
        else if (cfg_valid && cfg_ready)
            count_reg <= cfg_data;
    end

    tflb_front u_front (
        .clk(clk), .rst_n(rst_n), .push(start && !busy), .push_node(in_node),
        .full(full), .empty(empty), .pop(pop), .head(head)
    );

    tflb_back #(.MAX_NODES(MAX_NODES), .MAX_SAMPLES(MAX_SAMPLES)) u_back (
        .clk(clk), .rst_n(rst_n), .avail(!empty), .head(head), .pop(pop),
        .sample_count(count_reg), .strobe(strobe),
        .texel_red(texel_red), .texel_green(texel_green), .texel_blue(texel_blue),
        .texel_alpha(texel_alpha), .run_end(run_end)
    );
endmodule
`default_nettype wire
